[rtl/rdt_pkg.sv]
// Shared types and codes for the retransmit deadline table.
// Holds the slot entry layout, item kinds, result codes and controller states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdt_pkg;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_FORCE = 2'd2,
        KIND_TICK  = 2'd3
    } rdt_kind_t;

    typedef enum logic [1:0] {
        EV_STATUS  = 2'd0,
        EV_RESEND  = 2'd1,
        EV_PARTIAL = 2'd2,
        EV_ABANDON = 2'd3
    } rdt_event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_STATUS
    } rdt_state_t;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic        is_partial;
        logic [7:0]  header;
        logic [15:0] delay;
        logic [7:0]  attempts_left;
        logic [15:0] elapsed;
        logic [15:0] peer;
        logic [15:0] payload;
        logic [7:0]  part_index;
    } rdt_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        logic status;
    } rdt_cmd_t;

endpackage

`default_nettype wire

[rtl/rdt_ctrl.sv]
// Controller of the retransmit deadline table: sequences one slot scan per item.
// Depends on rdt_pkg for the state type and the command struct.
`timescale 1ns / 1ps
`default_nettype none

module rdt_ctrl #(
    parameter int SLOTS = 16,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output rdt_pkg::rdt_cmd_t  cmd,
    output logic [AW-1:0]      rd_addr
);

    rdt_pkg::rdt_state_t state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rdt_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            rdt_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                    state_next = rdt_pkg::ST_SCAN;
            end
            rdt_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == AW'(SLOTS - 1))
                    state_next = rdt_pkg::ST_LAST;
            end
            rdt_pkg::ST_LAST:
                state_next = rdt_pkg::ST_STATUS;
            rdt_pkg::ST_STATUS:
                state_next = rdt_pkg::ST_IDLE;
            default:
                state_next = rdt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b1;
        cmd.load   = 1'b0;
        cmd.rd_en  = 1'b0;
        cmd.status = 1'b0;
        rd_addr    = cnt_reg;
        case (state_reg)
            rdt_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            rdt_pkg::ST_SCAN:
                cmd.rd_en = 1'b1;
            rdt_pkg::ST_LAST:
                busy = 1'b1;
            rdt_pkg::ST_STATUS:
                cmd.status = 1'b1;
            default:
                busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[rtl/rdt_dp.sv]
// Datapath of the retransmit deadline table: slot memory, valid bits,
// per-slot update stage, nearest-deadline accumulator and result registers.
// Depends on rdt_pkg; driven by rdt_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module rdt_dp #(
    parameter int SLOTS = 16,
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rdt_pkg::rdt_cmd_t cmd,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic [1:0]        kind,
    input  wire logic [7:0]        header,
    input  wire logic [15:0]       delay_ticks,
    input  wire logic [7:0]        attempts,
    input  wire logic              entry_type,
    input  wire logic [15:0]       peer_id,
    input  wire logic [15:0]       payload_id,
    input  wire logic [7:0]        part_index,
    output logic                   result_strobe,
    output logic [1:0]             event_res,
    output logic [7:0]             out_header,
    output logic [15:0]            out_peer,
    output logic [15:0]            out_payload,
    output logic [7:0]             out_part_index,
    output logic [15:0]            ticks_to_next,
    output logic                   has_deadline,
    output logic                   add_refused,
    output logic                   last
);

    rdt_pkg::rdt_entry_t mem [SLOTS];
    rdt_pkg::rdt_entry_t rd_data_reg;
    logic [SLOTS-1:0]    valid_reg;

    // captured item
    rdt_pkg::rdt_kind_t  kind_reg;
    rdt_pkg::rdt_entry_t new_ent_reg;

    logic                pv_reg;
    logic [AW-1:0]       paddr_reg;
    logic                add_done_reg;
    logic                any_reg;
    logic [15:0]         best_reg;

    // update stage
    rdt_pkg::rdt_entry_t e;
    rdt_pkg::rdt_entry_t wr_data;
    logic                wr_en;
    logic                cur_valid;
    logic                valid_new;
    logic                live;
    logic                add_take;
    logic                emit;
    rdt_pkg::rdt_event_t emit_code;
    logic [15:0]         el_inc;
    logic [15:0]         left_cur;
    logic [15:0]         left;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg                  <= rdt_pkg::rdt_kind_t'(kind);
            new_ent_reg.is_partial    <= entry_type;
            new_ent_reg.header        <= header;
            new_ent_reg.delay         <= delay_ticks;
            new_ent_reg.attempts_left <= attempts;
            new_ent_reg.elapsed       <= '0;
            new_ent_reg.peer          <= peer_id;
            new_ent_reg.payload       <= entry_type ? 16'd0 : payload_id;
            new_ent_reg.part_index    <= entry_type ? part_index : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[paddr_reg] <= wr_data;
        if (cmd.rd_en)
            rd_data_reg <= mem[rd_addr];
        if (cmd.rd_en)
            paddr_reg <= rd_addr;
    end

    always_comb
    begin
        e         = rd_data_reg;
        cur_valid = valid_reg[paddr_reg];
        el_inc    = (e.elapsed == rdt_pkg::TICK_MAX) ? e.elapsed : e.elapsed + 16'd1;
        left_cur  = (e.elapsed >= e.delay) ? 16'd0 : e.delay - e.elapsed;
        wr_en     = 1'b0;
        wr_data   = e;
        valid_new = cur_valid;
        live      = 1'b0;
        left      = left_cur;
        add_take  = 1'b0;
        emit      = 1'b0;
        emit_code = rdt_pkg::EV_RESEND;
        if (pv_reg)
        begin
            case (kind_reg)
                rdt_pkg::KIND_ADD:
                begin
                    if (!cur_valid && !add_done_reg)
                    begin
                        // first free slot in scan order takes the new entry
                        add_take  = 1'b1;
                        wr_en     = 1'b1;
                        wr_data   = new_ent_reg;
                        valid_new = 1'b1;
                        live      = 1'b1;
                        left      = new_ent_reg.delay;
                    end
                    else
                        live = cur_valid;
                end
                rdt_pkg::KIND_ACK:
                begin
                    if (cur_valid && e.header == new_ent_reg.header)
                        valid_new = 1'b0;
                    else
                        live = cur_valid;
                end
                rdt_pkg::KIND_FORCE:
                begin
                    live = cur_valid;
                    if (cur_valid && e.header == new_ent_reg.header)
                    begin
                        wr_en           = 1'b1;
                        wr_data.elapsed = e.delay;
                        left            = 16'd0;
                    end
                end
                rdt_pkg::KIND_TICK:
                begin
                    if (cur_valid)
                    begin
                        wr_en = 1'b1;
                        if (el_inc >= e.delay)
                        begin
                            emit = 1'b1;
                            if (e.attempts_left == 8'd0)
                            begin
                                emit_code = rdt_pkg::EV_ABANDON;
                                valid_new = 1'b0;
                                wr_en     = 1'b0;
                            end
                            else
                            begin
                                emit_code = e.is_partial ? rdt_pkg::EV_PARTIAL
                                                         : rdt_pkg::EV_RESEND;
                                wr_data.attempts_left = e.attempts_left - 8'd1;
                                wr_data.elapsed       = 16'd0;
                                live                  = 1'b1;
                                left                  = e.delay;
                            end
                        end
                        else
                        begin
                            wr_data.elapsed = el_inc;
                            live            = 1'b1;
                            left            = e.delay - el_inc;
                        end
                    end
                end
                default:
                    live = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            pv_reg        <= 1'b0;
            add_done_reg  <= 1'b0;
            any_reg       <= 1'b0;
            result_strobe <= 1'b0;
        end
        else
        begin
            pv_reg        <= cmd.rd_en;
            result_strobe <= emit | cmd.status;
            if (pv_reg)
                valid_reg[paddr_reg] <= valid_new;
            if (cmd.load)
            begin
                add_done_reg <= 1'b0;
                any_reg      <= 1'b0;
            end
            else
            begin
                if (add_take)
                    add_done_reg <= 1'b1;
                if (live)
                    any_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (live && (!any_reg || left < best_reg))
            best_reg <= left;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            event_res      <= emit_code;
            out_header     <= e.header;
            out_peer       <= e.peer;
            out_payload    <= e.payload;
            out_part_index <= e.part_index;
            ticks_to_next  <= '0;
            has_deadline   <= 1'b0;
            add_refused    <= 1'b0;
            last           <= 1'b0;
        end
        else if (cmd.status)
        begin
            event_res      <= rdt_pkg::EV_STATUS;
            out_header     <= '0;
            out_peer       <= '0;
            out_payload    <= '0;
            out_part_index <= '0;
            ticks_to_next  <= any_reg ? best_reg : 16'd0;
            has_deadline   <= any_reg;
            add_refused    <= (kind_reg == rdt_pkg::KIND_ADD) && !add_done_reg;
            last           <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/retransmit_deadline_table.sv]
// Channel   Handshake                  Payload
// input     start, accepted when !busy kind, header, delay_ticks, attempts, entry_type,
//                                      peer_id, payload_id, part_index
// result    result_strobe, one cycle   event_res, out_header, out_peer, out_payload,
//                                      out_part_index, ticks_to_next, has_deadline,
//                                      add_refused, last
//
// Every item makes one read per slot, each slot written back in the cycle after its read,
// then passes the status cycle and the idle cycle that shows it.
// Events for due slots appear in slot order during the scan; the status result (last)
// closes the item and shows in the cycle busy drops.
// Reset clears the valid bits, so the table starts empty; no clearing pass is needed.
// Results cannot be held off by the receiver.
// Top level of the retransmit deadline table; instantiates rdt_ctrl and rdt_dp.
`timescale 1ns / 1ps
`default_nettype none

module retransmit_deadline_table_top #(
    parameter int SLOTS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  kind,
    input  wire logic [7:0]  header,
    input  wire logic [15:0] delay_ticks,
    input  wire logic [7:0]  attempts,
    input  wire logic        entry_type,
    input  wire logic [15:0] peer_id,
    input  wire logic [15:0] payload_id,
    input  wire logic [7:0]  part_index,
    output logic             result_strobe,
    output logic [1:0]       event_res,
    output logic [7:0]       out_header,
    output logic [15:0]      out_peer,
    output logic [15:0]      out_payload,
    output logic [7:0]       out_part_index,
    output logic [15:0]      ticks_to_next,
    output logic             has_deadline,
    output logic             add_refused,
    output logic             last
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    rdt_pkg::rdt_cmd_t cmd;
    logic [AW-1:0]     rd_addr;

    rdt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    rdt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .kind           (kind),
        .header         (header),
        .delay_ticks    (delay_ticks),
        .attempts       (attempts),
        .entry_type     (entry_type),
        .peer_id        (peer_id),
        .payload_id     (payload_id),
        .part_index     (part_index),
        .result_strobe  (result_strobe),
        .event_res      (event_res),
        .out_header     (out_header),
        .out_peer       (out_peer),
        .out_payload    (out_payload),
        .out_part_index (out_part_index),
        .ticks_to_next  (ticks_to_next),
        .has_deadline   (has_deadline),
        .add_refused    (add_refused),
        .last           (last)
    );

endmodule

`default_nettype wire

[rtl/rdt_chk.sv]
// Port-level checker for the retransmit deadline table, bound to the top level.
// Depends on rdt_pkg for the result codes.
`timescale 1ns / 1ps
`default_nettype none

module rdt_chk (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       result_strobe,
    input wire logic [1:0] event_res,
    input wire logic [7:0] out_header,
    input wire logic       add_refused,
    input wire logic       last
);

    // an accepted item keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    // the status result closes the item exactly when busy drops
    a_fall_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_strobe && last)
        else $error("busy dropped without a status result");

    // no event result while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && result_strobe |-> last)
        else $error("event result while idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last |-> event_res == rdt_pkg::EV_STATUS && out_header == 8'd0)
        else $error("status result with event fields");

    a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && event_res != rdt_pkg::EV_STATUS |-> !last && !add_refused)
        else $error("event result carries status fields");

endmodule

bind retransmit_deadline_table_top rdt_chk u_rdt_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .event_res     (event_res),
    .out_header    (out_header),
    .add_refused   (add_refused),
    .last          (last)
);

`default_nettype wire

[tb/sv/rdt_table_checker.sv]
// Checker for the retransmit deadline table: watches the item and result channels,
// keeps its own copy of the slot table and compares every result with the prediction.
// Depends on rdt_pkg for the item kinds, result codes, slot entry layout and TICK_MAX.
`timescale 1ns / 1ps

module rdt_table_checker #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  header,
    input  logic [15:0] delay_ticks,
    input  logic [7:0]  attempts,
    input  logic        entry_type,
    input  logic [15:0] peer_id,
    input  logic [15:0] payload_id,
    input  logic [7:0]  part_index,
    input  logic        result_strobe,
    input  logic [1:0]  event_res,
    input  logic [7:0]  out_header,
    input  logic [15:0] out_peer,
    input  logic [15:0] out_payload,
    input  logic [7:0]  out_part_index,
    input  logic [15:0] ticks_to_next,
    input  logic        has_deadline,
    input  logic        add_refused,
    input  logic        last,
    output int          mismatch_count,
    output int          awaited_count,
    output int          results_checked,
    output int          timer_events,
    output int          refused_adds
);

    typedef struct {
        rdt_pkg::rdt_event_t ev_code;
        logic [7:0]          hdr;
        logic [15:0]         peer;
        logic [15:0]         payload;
        logic [7:0]          part;
        logic [15:0]         ticks;
        logic                pending;
        logic                refused;
        logic                closing;
    } table_result_t;

    logic                slot_used [SLOTS];
    rdt_pkg::rdt_entry_t slot_tab  [SLOTS];
    table_result_t       awaited_results [$];

    task automatic log_error(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            log_error($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic push_event(input rdt_pkg::rdt_event_t ev_code, input int s);
        table_result_t r;
        r.ev_code = ev_code;
        r.hdr     = slot_tab[s].header;
        r.peer    = slot_tab[s].peer;
        r.payload = slot_tab[s].payload;
        r.part    = slot_tab[s].part_index;
        r.ticks   = '0;
        r.pending = 1'b0;
        r.refused = 1'b0;
        r.closing = 1'b0;
        awaited_results.push_back(r);
    endtask

    // Apply the item on the input ports to the table and queue what it produces.
    task automatic apply_table_item();
        table_result_t st;
        int            free_idx;
        logic          refused;
        logic          any_live;
        logic [15:0]   nearest;
        logic [15:0]   remaining;
        free_idx = -1;
        refused  = 1'b0;
        any_live = 1'b0;
        nearest  = '0;
        case (rdt_pkg::rdt_kind_t'(kind))
            rdt_pkg::KIND_ADD:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (!slot_used[s] && free_idx < 0)
                        free_idx = s;
                if (free_idx < 0)
                    refused = 1'b1;
                else
                begin
                    slot_used[free_idx] = 1'b1;
                    slot_tab[free_idx].is_partial    = entry_type;
                    slot_tab[free_idx].header        = header;
                    slot_tab[free_idx].delay         = delay_ticks;
                    slot_tab[free_idx].attempts_left = attempts;
                    slot_tab[free_idx].elapsed       = '0;
                    slot_tab[free_idx].peer          = peer_id;
                    slot_tab[free_idx].payload       = entry_type ? 16'd0 : payload_id;
                    slot_tab[free_idx].part_index    = entry_type ? part_index : 8'd0;
                end
            end
            rdt_pkg::KIND_ACK:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_used[s] && slot_tab[s].header == header)
                        slot_used[s] = 1'b0;
            end
            rdt_pkg::KIND_FORCE:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_used[s] && slot_tab[s].header == header)
                        slot_tab[s].elapsed = slot_tab[s].delay;
            end
            default:
            begin
                for (int s = 0; s < SLOTS; s++)
                    if (slot_used[s] && slot_tab[s].elapsed != rdt_pkg::TICK_MAX)
                        slot_tab[s].elapsed = slot_tab[s].elapsed + 16'd1;
                // serve due slots in slot order
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (slot_used[s] && slot_tab[s].elapsed >= slot_tab[s].delay)
                    begin
                        if (slot_tab[s].attempts_left == 8'd0)
                        begin
                            push_event(rdt_pkg::EV_ABANDON, s);
                            slot_used[s] = 1'b0;
                        end
                        else
                        begin
                            slot_tab[s].attempts_left = slot_tab[s].attempts_left - 8'd1;
                            push_event(slot_tab[s].is_partial ? rdt_pkg::EV_PARTIAL
                                                              : rdt_pkg::EV_RESEND, s);
                            slot_tab[s].elapsed = '0;
                        end
                    end
                end
            end
        endcase

        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_used[s])
            begin
                remaining = (slot_tab[s].elapsed >= slot_tab[s].delay) ? 16'd0 :
                            slot_tab[s].delay - slot_tab[s].elapsed;
                if (!any_live || remaining < nearest)
                    nearest = remaining;
                any_live = 1'b1;
            end
        end

        st.ev_code = rdt_pkg::EV_STATUS;
        st.hdr     = '0;
        st.peer    = '0;
        st.payload = '0;
        st.part    = '0;
        st.ticks   = nearest;
        st.pending = any_live;
        st.refused = refused;
        st.closing = 1'b1;
        awaited_results.push_back(st);
    endtask

    task automatic check_result();
        table_result_t want;
        if (awaited_results.size() == 0)
            log_error($sformatf("result with code %0d arrived with none outstanding",
                                event_res));
        else
        begin
            want = awaited_results.pop_front();
            check_field("event_res", event_res, want.ev_code);
            check_field("out_header", out_header, want.hdr);
            check_field("out_peer", out_peer, want.peer);
            check_field("out_payload", out_payload, want.payload);
            check_field("out_part_index", out_part_index, want.part);
            check_field("ticks_to_next", ticks_to_next, want.ticks);
            check_field("has_deadline", has_deadline, want.pending);
            check_field("add_refused", add_refused, want.refused);
            check_field("last", last, want.closing);
            results_checked++;
            if (want.ev_code != rdt_pkg::EV_STATUS)
                timer_events++;
            if (want.refused)
                refused_adds++;
        end
    endtask

    initial
    begin
        mismatch_count  = 0;
        awaited_count   = 0;
        results_checked = 0;
        timer_events    = 0;
        refused_adds    = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_used[s] = 1'b0;
                slot_tab[s]  = '0;
            end
            awaited_results.delete();
        end
        else
        begin
            if (result_strobe)
                check_result();
            if (start && !busy)
                apply_table_item();
        end
        awaited_count = awaited_results.size();
    end

endmodule

[tb/sv/testbench.sv]
// Top of the retransmit deadline table testbench: clock, reset, item stimulus and verdict.
// Instantiates retransmit_deadline_table_top and rdt_table_checker; uses rdt_pkg.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 455;
    localparam int CALM_TAIL    = 60;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 3);
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [7:0]  header;
    logic [15:0] delay_ticks;
    logic [7:0]  attempts;
    logic        entry_type;
    logic [15:0] peer_id;
    logic [15:0] payload_id;
    logic [7:0]  part_index;
    logic        result_strobe;
    logic [1:0]  event_res;
    logic [7:0]  out_header;
    logic [15:0] out_peer;
    logic [15:0] out_payload;
    logic [7:0]  out_part_index;
    logic [15:0] ticks_to_next;
    logic        has_deadline;
    logic        add_refused;
    logic        last;

    int mismatch_count;
    int awaited_count;
    int results_checked;
    int timer_events;
    int refused_adds;
    int items_sent;
    int cycle_count;

    retransmit_deadline_table_top #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .header(header),
        .delay_ticks(delay_ticks),
        .attempts(attempts),
        .entry_type(entry_type),
        .peer_id(peer_id),
        .payload_id(payload_id),
        .part_index(part_index),
        .result_strobe(result_strobe),
        .event_res(event_res),
        .out_header(out_header),
        .out_peer(out_peer),
        .out_payload(out_payload),
        .out_part_index(out_part_index),
        .ticks_to_next(ticks_to_next),
        .has_deadline(has_deadline),
        .add_refused(add_refused),
        .last(last)
    );

    rdt_table_checker #(
        .SLOTS(SLOTS)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .kind(kind),
        .header(header),
        .delay_ticks(delay_ticks),
        .attempts(attempts),
        .entry_type(entry_type),
        .peer_id(peer_id),
        .payload_id(payload_id),
        .part_index(part_index),
        .result_strobe(result_strobe),
        .event_res(event_res),
        .out_header(out_header),
        .out_peer(out_peer),
        .out_payload(out_payload),
        .out_part_index(out_part_index),
        .ticks_to_next(ticks_to_next),
        .has_deadline(has_deadline),
        .add_refused(add_refused),
        .last(last),
        .mismatch_count(mismatch_count),
        .awaited_count(awaited_count),
        .results_checked(results_checked),
        .timer_events(timer_events),
        .refused_adds(refused_adds)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles", cycle_count);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Drive one item at the falling edge and hold it until the block takes it.
    task automatic issue_item(input rdt_pkg::rdt_kind_t k, input logic [7:0] h,
                              input logic [15:0] d, input logic [7:0] a, input logic t,
                              input logic [15:0] p, input logic [15:0] pl,
                              input logic [7:0] pi);
        @(negedge clk);
        kind        = k;
        header      = h;
        delay_ticks = d;
        attempts    = a;
        entry_type  = t;
        peer_id     = p;
        payload_id  = pl;
        part_index  = pi;
        start       = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic idle_for(input int n);
        @(negedge clk);
        start = 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Mostly a small header pool so that acks and forces find their slots.
    function automatic logic [7:0] pick_header();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_item();
        int                 roll;
        rdt_pkg::rdt_kind_t k;
        logic [15:0]        d;
        logic [7:0]         a;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            k = rdt_pkg::KIND_ADD;
        else if (roll < 50)
            k = rdt_pkg::KIND_ACK;
        else if (roll < 65)
            k = rdt_pkg::KIND_FORCE;
        else
            k = rdt_pkg::KIND_TICK;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            d = 16'($urandom_range(0, 4));
        else if (roll < 90)
            d = 16'($urandom_range(5, 40));
        else
            d = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 3) != 0)
            a = 8'($urandom_range(0, 3));
        else
            a = 8'($urandom_range(0, 255));
        issue_item(k, pick_header(), d, a, 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        items_sent  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        kind        = rdt_pkg::KIND_ADD;
        header      = '0;
        delay_ticks = '0;
        attempts    = '0;
        entry_type  = 1'b0;
        peer_id     = '0;
        payload_id  = '0;
        part_index  = '0;
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: tick and ack find nothing
        issue_item(rdt_pkg::KIND_TICK, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_ACK, 8'hA5, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
        // fill every slot, extremes first
        issue_item(rdt_pkg::KIND_ADD, 8'h00, 16'h0000, 8'd2, 1'b0, 16'h0000, 16'hFFFF, 8'hFF);
        issue_item(rdt_pkg::KIND_ADD, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
        issue_item(rdt_pkg::KIND_ADD, 8'h01, 16'h0001, 8'h00, 1'b0, 16'h1234, 16'h8001, 8'h00);
        issue_item(rdt_pkg::KIND_ADD, 8'h01, 16'h0003, 8'h01, 1'b1, 16'hA5A5, 16'h0000, 8'h5A);
        for (int i = 4; i < SLOTS; i++)
            issue_item(rdt_pkg::KIND_ADD, 8'(2 + i % 4), 16'($urandom_range(1, 6)),
                       8'($urandom_range(0, 2)), 1'(i % 2), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        // full table refuses the add
        issue_item(rdt_pkg::KIND_ADD, 8'h07, 16'h0010, 8'h03, 1'b0, 16'h0101, 16'h0202, 8'h03);
        // force the longest delay: overdue until the tick, where elapsed saturates
        issue_item(rdt_pkg::KIND_FORCE, 8'hFF, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_TICK, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_FORCE, 8'h01, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_TICK, 8'h00, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_FORCE, 8'hC3, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        issue_item(rdt_pkg::KIND_ACK, 8'hFF, 16'h0000, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 19));
            random_item();
        end

        @(negedge clk);
        start = 1'b0;
        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d items; checked %0d results, %0d of them timer events.",
                 items_sent, results_checked, timer_events);
        $display("Adds refused on a full table: %0d; mismatches: %0d.",
                 refused_adds, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
